### sv/ndd_pkg.sv
package ndd_pkg;

    localparam int NDD_MAX_NODES  = 32;
    localparam int NDD_WORD_WIDTH = 48;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TABLE = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_SAT      = 2'd3;

endpackage

### sv/ndd_in_if.sv
interface ndd_in_if #(
    parameter int WORD_WIDTH = ndd_pkg::NDD_WORD_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [WORD_WIDTH-1:0] x_value;
    logic signed [WORD_WIDTH-1:0] y_value;
    logic                         last;

    modport source (output valid, cmd, x_value, y_value, last, input ready);
    modport sink   (input valid, cmd, x_value, y_value, last, output ready);
endinterface

### sv/ndd_out_if.sv
interface ndd_out_if #(
    parameter int WORD_WIDTH = ndd_pkg::NDD_WORD_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] value;
    logic [1:0]                   status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

### sv/newton_divided_difference_interp_unit.sv
// Newton divided-difference interpolator, signed Q16.(WORD_WIDTH-16), saturating.
// Load items store (x, y) nodes without leaving the idle state; the load that
// carries last rebuilds the coefficients in place and returns one status item.
// The build takes up to n(n-1)/2 steps, each an address, subtract, bit-serial
// restoring divide and write-back. An evaluate item walks the coefficients in
// Horner order through one 16-bit-digit multiplier. Nodes and coefficients
// live in two synchronous memories with registered reads.
module newton_divided_difference_interp_unit #(
    parameter int MAX_NODES  = ndd_pkg::NDD_MAX_NODES,
    parameter int WORD_WIDTH = ndd_pkg::NDD_WORD_WIDTH
) (
    input logic clk,
    input logic rst_n,
    ndd_in_if.sink    req,
    ndd_out_if.source rsp
);
    import ndd_pkg::*;

    localparam int W     = WORD_WIDTH;
    localparam int FRAC  = W - 16;
    localparam int AW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int QW    = W + FRAC;
    localparam int QCW   = $clog2(QW + 1);
    localparam int D     = (W + 15) / 16;
    localparam int DW    = D * 16;
    localparam int ACC_W = W + DW;
    localparam int DCW   = $clog2(D + 1);

    localparam logic [W-1:0]     MAXV   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     MINV   = {1'b1, {(W-1){1'b0}}};
    localparam logic [ACC_W-1:0] HALF_M = ACC_W'(1) << (W - 1);
    localparam logic [W-1:0]     QLIM   = W'(1) << (W - 1 - FRAC);

    typedef enum logic [3:0] {
        S_IDLE, S_B_ADDR, S_B_SUB, S_B_DIV, S_B_WB,
        S_E_LOAD, S_E_INIT, S_E_ADDR, S_E_SUB, S_E_MUL, S_E_ADD, S_RESULT
    } state_t;

    function automatic logic [W:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            sat_add = {1'b1, (s[W] ? MINV : MAXV)};
        else
            sat_add = {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1])
            sat_sub = {1'b1, (s[W] ? MINV : MAXV)};
        else
            sat_sub = {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        mag = a[W-1] ? (~a + W'(1)) : a;
    endfunction

    function automatic logic [W:0] from_mag(input logic [ACC_W-1:0] m, input logic neg);
        if (neg)
        begin
            if (m > HALF_M)
                from_mag = {1'b1, MINV};
            else
                from_mag = {1'b0, ~m[W-1:0] + W'(1)};
        end
        else
        begin
            if (m > HALF_M - ACC_W'(1))
                from_mag = {1'b1, MAXV};
            else
                from_mag = {1'b0, m[W-1:0]};
        end
    endfunction

    state_t           state_reg;
    logic [CW-1:0]    cnt_reg;
    logic             tready_reg;
    logic             dup_reg;
    logic             sat_reg;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    j_reg;
    logic [W-1:0]     xq_reg;
    logic [W-1:0]     r_reg;
    logic [QW-1:0]    dq_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dvs_reg;
    logic             neg_reg;
    logic [QCW-1:0]   qcnt_reg;
    logic [W-1:0]     ma_reg;
    logic [DW-1:0]    mb_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [DCW-1:0]   dcnt_reg;
    logic [1:0]       pend_reg;
    logic             ov_reg;
    logic [W-1:0]     value_reg;
    logic [1:0]       status_reg;

    logic [W-1:0] x_mem [MAX_NODES];
    logic [W-1:0] c_mem [MAX_NODES];
    logic [W-1:0] xa_q, xb_q, ca_q, cb_q;

    logic          accept;
    logic [CW-1:0] eff_cnt;
    logic          load_store;
    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic [W-1:0]  c_wdata;
    logic [W:0]    div_res;
    logic [W:0]    den_s, num_s, dsub_s, prod_s, hsum_s;
    logic [W:0]    t_div;
    logic          ge_div;
    logic [W+15:0] pp;
    logic          slot_free;

    assign accept     = req.valid && (state_reg == S_IDLE);
    assign eff_cnt    = tready_reg ? '0 : cnt_reg;
    assign load_store = accept && (req.cmd == CMD_LOAD) && (eff_cnt < CW'(MAX_NODES));
    assign c_we       = load_store || (state_reg == S_B_WB);
    assign c_waddr    = (state_reg == S_B_WB) ? idx_reg : eff_cnt[AW-1:0];
    assign c_wdata    = (state_reg == S_B_WB) ? div_res[W-1:0] : W'(req.y_value);
    assign slot_free  = !ov_reg || rsp.ready;

    always_comb
    begin
        if (dq_reg[QW-1:FRAC] > QLIM)
            div_res = {1'b1, (neg_reg ? MINV : MAXV)};
        else
            div_res = from_mag(ACC_W'(dq_reg[W-1:0]), neg_reg);
    end

    assign den_s  = sat_sub(xa_q, xb_q);
    assign num_s  = sat_sub(ca_q, cb_q);
    assign dsub_s = sat_sub(xq_reg, xa_q);
    assign prod_s = from_mag(acc_reg >> FRAC, neg_reg);
    assign hsum_s = sat_add(ca_q, prod_s[W-1:0]);
    assign t_div  = {rem_reg, dq_reg[QW-1]};
    assign ge_div = t_div >= {1'b0, dvs_reg};
    assign pp     = (W+16)'(ma_reg) * (W+16)'(mb_reg[DW-1 -: 16]);

    always_ff @(posedge clk)
    begin
        if (load_store)
            x_mem[eff_cnt[AW-1:0]] <= W'(req.x_value);
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        xa_q <= x_mem[idx_reg];
        xb_q <= x_mem[AW'(idx_reg - j_reg)];
        ca_q <= c_mem[idx_reg];
        cb_q <= c_mem[AW'(idx_reg - AW'(1))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            tready_reg <= 1'b0;
            dup_reg    <= 1'b0;
            sat_reg    <= 1'b0;
            idx_reg    <= '0;
            j_reg      <= '0;
            xq_reg     <= '0;
            r_reg      <= '0;
            dq_reg     <= '0;
            rem_reg    <= '0;
            dvs_reg    <= '0;
            neg_reg    <= 1'b0;
            qcnt_reg   <= '0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            acc_reg    <= '0;
            dcnt_reg   <= '0;
            pend_reg   <= ST_OK;
            ov_reg     <= 1'b0;
            value_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (state_reg == S_RESULT && slot_free)
                ov_reg <= 1'b1;
            else if (rsp.ready)
                ov_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        sat_reg <= 1'b0;
                        r_reg   <= '0;
                        xq_reg  <= W'(req.x_value);
                        if (req.cmd == CMD_LOAD)
                        begin
                            if (tready_reg)
                                dup_reg <= 1'b0;
                            // a load opens a node set after a finished table, else extends it while below capacity
                            tready_reg <= req.last;
                            cnt_reg    <= eff_cnt + CW'(load_store);
                            if (req.last)
                            begin
                                if (eff_cnt + CW'(load_store) > CW'(1))
                                begin
                                    j_reg     <= AW'(1);
                                    idx_reg   <= AW'(eff_cnt + CW'(load_store) - CW'(1));
                                    state_reg <= S_B_ADDR;
                                end
                                else
                                begin
                                    pend_reg  <= ST_OK;
                                    state_reg <= S_RESULT;
                                end
                            end
                        end
                        else if (!tready_reg || cnt_reg == '0)
                        begin
                            pend_reg  <= ST_NO_TABLE;
                            state_reg <= S_RESULT;
                        end
                        else if (dup_reg)
                        begin
                            pend_reg  <= ST_DUP;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            idx_reg   <= AW'(cnt_reg - CW'(1));
                            state_reg <= S_E_LOAD;
                        end
                    end
                end
                S_B_ADDR:
                begin
                    state_reg <= S_B_SUB;
                end
                S_B_SUB:
                begin
                    if (den_s[W-1:0] == '0)
                    begin
                        dup_reg   <= 1'b1;
                        pend_reg  <= ST_DUP;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        sat_reg   <= sat_reg | den_s[W] | num_s[W];
                        dq_reg    <= {mag(num_s[W-1:0]), {FRAC{1'b0}}};
                        rem_reg   <= '0;
                        dvs_reg   <= mag(den_s[W-1:0]);
                        neg_reg   <= num_s[W-1] ^ den_s[W-1];
                        qcnt_reg  <= '0;
                        state_reg <= S_B_DIV;
                    end
                end
                S_B_DIV:
                begin
                    // one quotient bit per cycle, remainder stays below the divisor
                    rem_reg  <= ge_div ? W'(t_div - {1'b0, dvs_reg}) : t_div[W-1:0];
                    dq_reg   <= {dq_reg[QW-2:0], ge_div};
                    qcnt_reg <= qcnt_reg + QCW'(1);
                    if (qcnt_reg == QCW'(QW - 1))
                        state_reg <= S_B_WB;
                end
                S_B_WB:
                begin
                    sat_reg <= sat_reg | div_res[W];
                    if (idx_reg == j_reg)
                    begin
                        if (CW'(j_reg) + CW'(1) == cnt_reg)
                        begin
                            pend_reg  <= (sat_reg | div_res[W]) ? ST_SAT : ST_OK;
                            state_reg <= S_RESULT;
                        end
                        else
                        begin
                            j_reg     <= j_reg + AW'(1);
                            idx_reg   <= AW'(cnt_reg - CW'(1));
                            state_reg <= S_B_ADDR;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_B_ADDR;
                    end
                end
                S_E_LOAD:
                begin
                    state_reg <= S_E_INIT;
                end
                S_E_INIT:
                begin
                    r_reg <= ca_q;
                    if (idx_reg == '0)
                    begin
                        pend_reg  <= ST_OK;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_E_ADDR;
                    end
                end
                S_E_ADDR:
                begin
                    state_reg <= S_E_SUB;
                end
                S_E_SUB:
                begin
                    sat_reg   <= sat_reg | dsub_s[W];
                    ma_reg    <= mag(r_reg);
                    mb_reg    <= DW'(mag(dsub_s[W-1:0])) << (DW - W);
                    neg_reg   <= r_reg[W-1] ^ dsub_s[W-1];
                    acc_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= S_E_MUL;
                end
                S_E_MUL:
                begin
                    // most significant digit first
                    acc_reg  <= (acc_reg << 16) + ACC_W'(pp);
                    mb_reg   <= mb_reg << 16;
                    dcnt_reg <= dcnt_reg + DCW'(1);
                    if (dcnt_reg == DCW'(D - 1))
                        state_reg <= S_E_ADD;
                end
                S_E_ADD:
                begin
                    r_reg   <= hsum_s[W-1:0];
                    sat_reg <= sat_reg | prod_s[W] | hsum_s[W];
                    if (idx_reg == '0)
                    begin
                        pend_reg  <= (sat_reg | prod_s[W] | hsum_s[W]) ? ST_SAT : ST_OK;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - AW'(1);
                        state_reg <= S_E_ADDR;
                    end
                end
                S_RESULT:
                begin
                    if (slot_free)
                    begin
                        value_reg  <= r_reg;
                        status_reg <= pend_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = ov_reg;
    assign rsp.value  = value_reg;
    assign rsp.status = status_reg;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_NODES))
        else $error("node count above capacity");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (status_reg == ST_NO_TABLE || status_reg == ST_DUP)) |-> value_reg == '0)
        else $error("error result with nonzero value");

    a_build_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B_WB) |-> (idx_reg >= j_reg && idx_reg != '0))
        else $error("build writes outside the active column");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && slot_free) |=> (ov_reg && state_reg == S_IDLE))
        else $error("result item not posted");
`endif

endmodule

### sim/ndd_checker.sv
`timescale 1ns / 1ps

module ndd_checker (
    input  logic clk,
    input  logic rst_n,
    ndd_in_if    req,
    ndd_out_if   rsp,
    output int   fail_count,
    output int   pending
);
    import ndd_pkg::*;

    localparam int     FRAC  = NDD_WORD_WIDTH - 16;
    localparam longint MAXV  = (longint'(1) <<< (NDD_WORD_WIDTH - 1)) - 1;
    localparam longint MINV  = -MAXV - 1;
    localparam logic [127:0] HALF = 128'd1 << (NDD_WORD_WIDTH - 1);

    typedef struct packed {
        logic signed [NDD_WORD_WIDTH-1:0] value;
        logic [1:0]                       status;
    } interp_result_t;

    interp_result_t expected_results[$];

    longint node_x[NDD_MAX_NODES];
    longint coeff[NDD_MAX_NODES];
    int     node_cnt;
    bit     have_table;
    bit     dup_nodes;
    bit     saturated;

    function automatic logic [127:0] mag_of(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint clamp_mag(logic [127:0] mag, bit neg);
        if (neg) begin
            if (mag > HALF) begin
                saturated = 1;
                return MINV;
            end
            if (mag == HALF)
                return MINV;
            return -longint'(mag);
        end
        if (mag > 128'(MAXV)) begin
            saturated = 1;
            return MAXV;
        end
        return longint'(mag);
    endfunction

    function automatic longint q_add(longint a, longint b);
        if (b > 0 && a > MAXV - b) begin
            saturated = 1;
            return MAXV;
        end
        if (b < 0 && a < MINV - b) begin
            saturated = 1;
            return MINV;
        end
        return a + b;
    endfunction

    function automatic longint q_sub(longint a, longint b);
        if (b < 0 && a > MAXV + b) begin
            saturated = 1;
            return MAXV;
        end
        if (b > 0 && a < MINV + b) begin
            saturated = 1;
            return MINV;
        end
        return a - b;
    endfunction

    function automatic longint q_mul(longint a, longint b);
        return clamp_mag((mag_of(a) * mag_of(b)) >> FRAC, (a < 0) != (b < 0));
    endfunction

    // restoring division truncates toward zero, so a wide divide matches it
    function automatic longint q_div(longint a, longint b);
        return clamp_mag((mag_of(a) << FRAC) / mag_of(b), (a < 0) != (b < 0));
    endfunction

    task automatic build_coefficients();
        longint den;
        for (int j = 1; j < node_cnt; j++) begin
            for (int i = node_cnt - 1; i >= j; i--) begin
                den = q_sub(node_x[i], node_x[i-j]);
                if (node_x[i] == node_x[i-j] || den == 0) begin
                    dup_nodes = 1;
                    return;
                end
                coeff[i] = q_div(q_sub(coeff[i], coeff[i-1]), den);
            end
        end
    endtask

    task automatic predict_item(logic cmd, longint xv, longint yv, logic last);
        interp_result_t r;
        longint acc;
        saturated = 0;
        r.value   = '0;
        if (cmd == CMD_LOAD) begin
            if (have_table) begin
                node_cnt   = 0;
                have_table = 0;
                dup_nodes  = 0;
            end
            if (node_cnt < NDD_MAX_NODES) begin
                node_x[node_cnt] = xv;
                coeff[node_cnt]  = yv;
                node_cnt++;
            end
            if (!last)
                return;
            build_coefficients();
            have_table = 1;
            r.status = dup_nodes ? ST_DUP : (saturated ? ST_SAT : ST_OK);
        end else if (!have_table || node_cnt == 0) begin
            r.status = ST_NO_TABLE;
        end else if (dup_nodes) begin
            r.status = ST_DUP;
        end else begin
            acc = coeff[node_cnt-1];
            for (int k = node_cnt - 2; k >= 0; k--)
                acc = q_add(coeff[k], q_mul(acc, q_sub(xv, node_x[k])));
            r.value  = acc[NDD_WORD_WIDTH-1:0];
            r.status = saturated ? ST_SAT : ST_OK;
        end
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        interp_result_t exp_r;
        if (!rst_n) begin
            expected_results.delete();
            node_cnt   = 0;
            have_table = 0;
            dup_nodes  = 0;
            fail_count = 0;
            pending    = 0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item value=%0d status=%0d",
                           rsp.value, rsp.status);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (rsp.value !== exp_r.value) begin
                        $error("value: expected %0d actual %0d", exp_r.value, rsp.value);
                        fail_count++;
                    end
                    if (rsp.status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, rsp.status);
                        fail_count++;
                    end
                end
            end
            if (req.valid && req.ready)
                predict_item(req.cmd, longint'(req.x_value), longint'(req.y_value),
                             req.last);
            pending = expected_results.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ndd_pkg::*;

    localparam int W         = NDD_WORD_WIDTH;
    localparam int N_ITEMS   = 1700;
    localparam int MAX_CYC   = 3000000;
    localparam int HOLD_CYC  = 3000;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(1) <<< (W - 16);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent;
    bit   calm;
    bit   hold_req;
    int   cycles;

    ndd_in_if  #(.WORD_WIDTH(W)) req ();
    ndd_out_if #(.WORD_WIDTH(W)) rsp ();

    newton_divided_difference_interp_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    ndd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [W-1:0] rand_word();
        return W'({$urandom, $urandom});
    endfunction

    // random word with a random number of significant bits
    function automatic logic signed [W-1:0] rand_scaled();
        return rand_word() >>> $urandom_range(0, W - 2);
    endfunction

    task automatic send_item(logic cmd, logic signed [W-1:0] xv,
                             logic signed [W-1:0] yv, logic last);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req.valid = 0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req.valid   = 1;
        req.cmd     = cmd;
        req.x_value = xv;
        req.y_value = yv;
        req.last    = last;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
    endtask

    task automatic send_node_set(int n, logic signed [W-1:0] x0,
                                 logic signed [W-1:0] step, bit allow_dup);
        logic signed [W-1:0] xv;
        for (int i = 0; i < n; i++) begin
            xv = x0 + step * i + (rand_word() >>> ($urandom_range(W - 12, W - 1)));
            if (allow_dup && i > 0 && $urandom_range(0, 15) == 0)
                xv = x0 + step * (i - 1);
            send_item(CMD_LOAD, xv, rand_scaled(), i == n - 1);
        end
    endtask

    // output side stalls, including one long hold while the sender keeps going
    initial begin
        rsp.ready = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                rsp.ready = 0;
                repeat (HOLD_CYC) @(negedge clk);
                hold_req = 0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp.ready = 0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rsp.ready = 1;
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > MAX_CYC) begin
                $display("newton_divided_difference_interp_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        int n;
        logic signed [W-1:0] step;
        logic signed [W-1:0] x0;
        req.valid   = 0;
        req.cmd     = CMD_LOAD;
        req.x_value = '0;
        req.y_value = '0;
        req.last    = 0;
        calm        = 0;
        hold_req    = 0;
        sent        = 0;
        rst_n       = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // query before any table exists
        send_item(CMD_EVAL, ONE, '0, 0);
        // single node, constant polynomial
        send_item(CMD_LOAD, ONE, WMAX, 1);
        send_item(CMD_EVAL, WMIN, '0, 0);
        // duplicate abscissa
        send_item(CMD_LOAD, ONE, ONE, 0);
        send_item(CMD_LOAD, ONE, -ONE, 1);
        send_item(CMD_EVAL, '0, '0, 0);
        // extreme fields, saturating build and evaluation
        send_item(CMD_LOAD, WMAX, WMAX, 0);
        send_item(CMD_LOAD, WMIN, WMIN, 0);
        send_item(CMD_LOAD, '0, '1, 1);
        send_item(CMD_EVAL, WMAX, WMAX, 1);
        send_item(CMD_EVAL, WMIN, '0, 0);
        send_item(CMD_EVAL, '1, '0, 0);
        // full set plus one node beyond capacity, last on the dropped one
        for (int i = 0; i <= NDD_MAX_NODES; i++)
            send_item(CMD_LOAD, ONE * (i - 16), rand_scaled() >>> 8,
                      i == NDD_MAX_NODES);
        send_item(CMD_EVAL, ONE / 2, '0, 0);
        send_item(CMD_EVAL, -ONE * 17, '0, 0);

        while (sent < N_ITEMS) begin
            if (sent > N_ITEMS - 200)
                calm = 1;
            if ($urandom_range(0, 6) == 0) begin
                // noise: any field value at all
                send_item(1'($urandom), rand_word(), rand_word(), 1'($urandom));
            end else begin
                n    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(2, 6);
                step = ONE * $urandom_range(1, 4) >>> $urandom_range(0, 6);
                if ($urandom_range(0, 1)) step = -step;
                x0   = rand_scaled() >>> 6;
                send_node_set(n, x0, step, 1);
                if (!hold_req && sent > N_ITEMS / 2 && sent < N_ITEMS / 2 + 40)
                    hold_req = 1;
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 5) == 0)
                        send_item(CMD_EVAL, rand_word(), rand_word(), 1'($urandom));
                    else
                        send_item(CMD_EVAL, x0 + step * $urandom_range(0, n)
                                  + (rand_word() >>> (W - 20)), '0, 0);
                end
            end
        end

        @(negedge clk);
        req.valid = 0;
        while (pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (fail_count == 0)
            $display("newton_divided_difference_interp_unit verification clean");
        else
            $display("newton_divided_difference_interp_unit verification failed");
        $finish;
    end

endmodule
